// ----- design/temperature_softmax_l2_normalize_defines.svh -----
// Assertion macros shared by the temperature softmax design.
// Expects signals named clock and reset in the using module.
`ifndef TEMPERATURE_SOFTMAX_L2_NORMALIZE_DEFINES_SVH
`define TEMPERATURE_SOFTMAX_L2_NORMALIZE_DEFINES_SVH

// property held on every clock edge outside reset
`define TSL2N_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequence required in the cycle after the antecedent
`define TSL2N_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tsl2n_pkg.sv -----
// Types, constants and the exp table for the temperature softmax block.
// No dependencies.
package tsl2n_pkg;

   localparam int LOGIT_W = 16;
   localparam int TEMP_W  = 16;
   localparam int CNT_W   = 7;
   localparam int IDX_W   = 6;
   localparam int E_W     = 17;
   localparam int PROB_W  = 16;

   localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd13107;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic REG_TEMPERATURE = 1'b0;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] max;
      logic [CNT_W-1:0]          cnt;
      logic                      ovf;
      logic [TEMP_W-1:0]         temp;
   } job_type;

   typedef struct packed {
      logic                      we;
      logic [IDX_W-1:0]          addr;
      logic signed [LOGIT_W-1:0] data;
   } wr_type;

   // 2^(-k/16) in Q16
   function automatic logic [E_W-1:0] pow2_frac(input logic [4:0] k);
      logic [E_W-1:0] v;
      case (k)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62757;
         5'd2:    v = 17'd60096;
         5'd3:    v = 17'd57548;
         5'd4:    v = 17'd55108;
         5'd5:    v = 17'd52772;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48393;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         5'd16:   v = 17'd32768;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

endpackage

// ----- design/tsl2n_if.sv -----
// Request and response channel interfaces (valid/ready).
// Depends on tsl2n_pkg.
interface tsl2n_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [tsl2n_pkg::LOGIT_W-1:0] logit;
   logic                               last;
   modport source(output valid, logit, last, input ready);
   modport sink(input valid, logit, last, output ready);
endinterface

interface tsl2n_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tsl2n_pkg::PROB_W-1:0] probability;
   logic [tsl2n_pkg::IDX_W-1:0]  index;
   logic                        last_res;
   logic                        truncated;
   modport source(output valid, probability, index, last_res, truncated, input ready);
   modport sink(input valid, probability, index, last_res, truncated, output ready);
endinterface

// ----- design/temperature_softmax_l2_normalize.sv -----
// Loading: one logit request per cycle until the request with last set, while
// no job is queued and no exp pass runs. After last: divide and exp per element,
// square root, divide per result; new logits are taken again once the exp pass ends.
// Rate is set by the shared 1-bit-per-cycle divider and the bitwise square root.
// Synchronous active-high reset clears control; temperature returns to 0.8 (Q2.14).
// Depends on tsl2n_pkg, tsl2n_if, tsl2n_front, tsl2n_fifo, tsl2n_back.
module temperature_softmax_l2_normalize #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   tsl2n_req_if.sink   req_chan,
   tsl2n_rsp_if.source rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [tsl2n_pkg::TEMP_W-1:0] temp_ff, temp_in;
   tsl2n_pkg::wr_type  wr;
   tsl2n_pkg::job_type push_job, pop_job;
   logic push, pop, empty, busy, lock;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tsl2n_pkg::REG_TEMPERATURE) ? {16'b0, temp_ff} : 32'b0;

   always_comb begin
      temp_in = temp_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == tsl2n_pkg::REG_TEMPERATURE)) begin
         temp_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= tsl2n_pkg::TEMP_RESET;
      end else begin
         temp_ff <= temp_in;
      end
   end

   assign lock = busy || !empty;

   tsl2n_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .temperature (temp_ff),
      .lock        (lock),
      .wr          (wr),
      .push        (push),
      .job         (push_job)
   );

   tsl2n_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (empty)
   );

   tsl2n_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .job_empty  (empty),
      .job_data   (pop_job),
      .job_pop    (pop),
      .logit_busy (busy),
      .rsp        (rsp_chan)
   );

endmodule

// ----- design/tsl2n_front.sv -----
// Front end: accepts logit requests, tracks max/count/overflow, emits jobs.
// Depends on tsl2n_pkg and tsl2n_req_if.
module tsl2n_front #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   tsl2n_req_if.sink                  req,
   input  logic [tsl2n_pkg::TEMP_W-1:0] temperature,
   input  logic                       lock,
   output tsl2n_pkg::wr_type          wr,
   output logic                       push,
   output tsl2n_pkg::job_type         job
);

   logic signed [tsl2n_pkg::LOGIT_W-1:0] max_ff, max_in, max_upd;
   logic [tsl2n_pkg::CNT_W-1:0]          count_ff, count_in, count_upd;
   logic                                 ovf_ff, ovf_in, ovf_upd;
   logic                                 accept, room;

   assign req.ready = !lock;
   assign accept    = req.valid && req.ready;
   assign room      = count_ff < tsl2n_pkg::CNT_W'(MAX_ELEMENTS);

   always_comb begin
      max_upd   = max_ff;
      count_upd = count_ff;
      ovf_upd   = ovf_ff;
      if (room) begin
         if (req.logit > max_ff) begin
            max_upd = req.logit;
         end
         count_upd = count_ff + 1'b1;
      end else begin
         ovf_upd = 1'b1;
      end
      max_in   = max_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req.last) begin
            max_in   = 16'sh8000;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            max_in   = max_upd;
            count_in = count_upd;
            ovf_in   = ovf_upd;
         end
      end
   end

   assign wr.we   = accept && room;
   assign wr.addr = tsl2n_pkg::IDX_W'(count_ff);
   assign wr.data = req.logit;

   assign push     = accept && req.last;
   assign job.max  = max_upd;
   assign job.cnt  = count_upd;
   assign job.ovf  = ovf_upd;
   assign job.temp = (temperature == '0) ? tsl2n_pkg::TEMP_W'(1) : temperature;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= 16'sh8000;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         max_ff   <= max_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- design/tsl2n_fifo.sv -----
// Two-entry job queue between front and back end.
// Depends on tsl2n_pkg.
module tsl2n_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tsl2n_pkg::job_type push_data,
   input  logic               pop,
   output tsl2n_pkg::job_type pop_data,
   output logic               empty
);

   tsl2n_pkg::job_type   mem_ff [2];
   logic                 wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && (cnt_ff != 2'd2);
   assign do_pop  = pop && !empty;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- design/tsl2n_back.sv -----
// Back end: exp pass over stored logits, square-root norm, normalize pass.
// Depends on tsl2n_pkg, tsl2n_rsp_if and the assertion macro header.
`include "temperature_softmax_l2_normalize_defines.svh"

module tsl2n_back #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  tsl2n_pkg::wr_type  wr,
   input  logic               job_empty,
   input  tsl2n_pkg::job_type job_data,
   output logic               job_pop,
   output logic               logit_busy,
   tsl2n_rsp_if.source        rsp
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_RD   = 12'b000000000010,
      ST_DIFF = 12'b000000000100,
      ST_DIVA = 12'b000000001000,
      ST_MUL  = 12'b000000010000,
      ST_INTP = 12'b000000100000,
      ST_SQ   = 12'b000001000000,
      ST_SQRT = 12'b000010000000,
      ST_NRD  = 12'b000100000000,
      ST_NLD  = 12'b001000000000,
      ST_DIVB = 12'b010000000000,
      ST_EMIT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] logit_mem [MAX_ELEMENTS];
   logic [16:0]        e_mem [MAX_ELEMENTS];
   logic signed [15:0] lrd_ff;
   logic [16:0]        erd_ff;

   tsl2n_pkg::job_type job_ff, job_in;
   logic [6:0]  idx_ff, idx_in;
   logic [40:0] rem_ff, rem_in;
   logic [43:0] dvs_ff, dvs_in, rem_sub;
   logic [20:0] q_ff, q_in, q_step;
   logic [4:0]  bc_ff, bc_in;
   logic [37:0] y_ff, y_in;
   logic [16:0] e_ff, e_in;
   logic [39:0] sum_ff, sum_in;
   logic [55:0] sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in, strial;
   logic [27:0] norm_ff, norm_in;
   logic        ge, last_idx;
   logic [15:0] diff;
   logic [4:0]  k;
   logic [11:0] r;
   logic [16:0] ta, tb, tdelta, v;
   logic [28:0] iprod;
   logic [5:0]  n;

   logic        ov_ff, ov_in;
   logic [15:0] op_ff, op_in;
   logic [5:0]  oi_ff, oi_in;
   logic        ol_ff, ol_in, ot_ff, ot_in;
   logic        out_free;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         logit_mem[wr.addr[AW-1:0]] <= wr.data;
      end
      lrd_ff <= logit_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQ) begin
         e_mem[idx_ff[AW-1:0]] <= e_ff;
      end
      erd_ff <= e_mem[idx_ff[AW-1:0]];
   end

   assign out_free   = !ov_ff || rsp.ready;
   assign last_idx   = (idx_ff == job_ff.cnt - 1'b1);
   assign rem_sub    = {3'b0, rem_ff} - dvs_ff;
   assign ge         = ({3'b0, rem_ff} >= dvs_ff);
   assign q_step     = {q_ff[19:0], ge};
   assign diff       = 16'(17'(job_ff.max) - 17'(lrd_ff));
   assign n          = y_ff[37:32];
   assign k          = {1'b0, y_ff[31:28]};
   assign r          = y_ff[27:16];
   assign ta         = tsl2n_pkg::pow2_frac(k);
   assign tb         = tsl2n_pkg::pow2_frac(k + 5'd1);
   assign tdelta     = ta - tb;
   assign iprod      = 29'(tdelta[11:0] * r);
   assign v          = ta - 17'(iprod >> 12);
   assign strial     = sres_ff + sbit_ff;
   assign logit_busy = (state_ff == ST_RD) || (state_ff == ST_DIFF) || (state_ff == ST_DIVA)
                    || (state_ff == ST_MUL) || (state_ff == ST_INTP) || (state_ff == ST_SQ);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      q_in     = q_ff;
      bc_in    = bc_ff;
      y_in     = y_ff;
      e_in     = e_ff;
      sum_in   = sum_ff;
      sx_in    = sx_ff;
      sres_in  = sres_ff;
      sbit_in  = sbit_ff;
      norm_in  = norm_ff;
      job_pop  = 1'b0;
      ov_in    = ov_ff && !rsp.ready;
      op_in    = op_ff;
      oi_in    = oi_ff;
      ol_in    = ol_ff;
      ot_in    = ot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               idx_in   = '0;
               sum_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if ({diff, 1'b0} >= {1'b0, job_ff.temp}) begin
               e_in     = '0;
               state_in = ST_SQ;
            end else begin
               rem_in   = {3'b0, diff, 22'b0};
               dvs_in   = {8'b0, job_ff.temp, 20'b0};
               q_in     = '0;
               bc_in    = 5'd20;
               state_in = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (ge) begin
               rem_in = rem_sub[40:0];
            end
            q_in   = q_step;
            dvs_in = dvs_ff >> 1;
            bc_in  = bc_ff - 1'b1;
            if (bc_ff == 5'd0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            y_in     = 38'(q_ff * tsl2n_pkg::LOG2E_Q16);
            state_in = ST_INTP;
         end
         ST_INTP: begin
            e_in     = n[5] ? 17'd0 : (v >> n[4:0]);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sum_in = sum_ff + 40'(e_ff * e_ff);
            if (last_idx) begin
               sx_in    = {sum_in, 16'b0};
               sres_in  = '0;
               sbit_in  = 56'd1 << 54;
               bc_in    = 5'd27;
               state_in = ST_SQRT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_SQRT: begin
            if (sx_ff >= strial) begin
               sx_in   = sx_ff - strial;
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            bc_in   = bc_ff - 1'b1;
            if (bc_ff == 5'd0) begin
               norm_in  = (sres_in[27:0] == '0) ? 28'd1 : sres_in[27:0];
               idx_in   = '0;
               state_in = ST_NRD;
            end
         end
         ST_NRD: begin
            state_in = ST_NLD;
         end
         ST_NLD: begin
            rem_in   = {1'b0, erd_ff, 23'b0} + 41'(norm_ff >> 1);
            dvs_in   = {norm_ff, 16'b0};
            q_in     = '0;
            bc_in    = 5'd16;
            state_in = ST_DIVB;
         end
         ST_DIVB: begin
            if (ge) begin
               rem_in = rem_sub[40:0];
            end
            q_in   = q_step;
            dvs_in = dvs_ff >> 1;
            bc_in  = bc_ff - 1'b1;
            if (bc_ff == 5'd0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1;
               op_in = q_ff[15:0];
               oi_in = 6'(idx_ff);
               ol_in = last_idx;
               ot_in = job_ff.ovf;
               if (last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_NRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      bc_ff   <= bc_in;
      y_ff    <= y_in;
      e_ff    <= e_in;
      sum_ff  <= sum_in;
      sx_ff   <= sx_in;
      sres_ff <= sres_in;
      sbit_ff <= sbit_in;
      norm_ff <= norm_in;
      op_ff   <= op_in;
      oi_ff   <= oi_in;
      ol_ff   <= ol_in;
      ot_ff   <= ot_in;
   end

   assign rsp.valid       = ov_ff;
   assign rsp.probability = op_ff;
   assign rsp.index       = oi_ff;
   assign rsp.last_res    = ol_ff;
   assign rsp.truncated   = ot_ff;

   `TSL2N_ASSERT(a_div_bound, ((state_ff == ST_DIVA) || (state_ff == ST_DIVB)) |-> ({4'b0, rem_ff} < {dvs_ff, 1'b0}), "divider remainder out of range")
   `TSL2N_ASSERT(a_idx_range, ((state_ff == ST_SQ) || (state_ff == ST_EMIT)) |-> (idx_ff < job_ff.cnt), "element index beyond vector length")
   `TSL2N_ASSERT(a_norm_nonzero, (state_ff == ST_NLD) |-> (norm_ff != '0), "zero norm in normalize pass")
   `TSL2N_ASSERT_NEXT(a_sqrt_done, (state_ff == ST_SQRT) && (bc_ff == 5'd0), state_ff == ST_NRD, "square root did not finish")

endmodule
